### src/srisc_pkg.sv
// shared types and constants for the sixteen-bit risc core step block
// no dependencies; used by srisc_exec and sixteen_bit_risc_core_step
package srisc_pkg;

  localparam int MemWordsDef = 512;
  localparam int RegCount    = 8;
  localparam int RegIdxW     = $clog2(RegCount);

  // request op codes
  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpStep  = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  // instruction opcodes, bits 15:12
  localparam logic [3:0] OpcRtype = 4'd0;
  localparam logic [3:0] OpcJump  = 4'd2;
  localparam logic [3:0] OpcLw    = 4'd4;
  localparam logic [3:0] OpcSw    = 4'd5;
  localparam logic [3:0] OpcAddi  = 4'd8;
  localparam logic [3:0] OpcBeq   = 4'd9;

  // r-type funct codes
  localparam logic [2:0] FnAdd = 3'd0;
  localparam logic [2:0] FnSub = 3'd1;
  localparam logic [2:0] FnAnd = 3'd2;
  localparam logic [2:0] FnOr  = 3'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [8:0]         word_address;
    logic [15:0]        word_data;
    logic [RegIdxW-1:0] register_select;
  } srisc_in_t;

  typedef struct packed {
    logic [11:0]        program_counter;
    logic               halted;
    logic               reg_written;
    logic [RegIdxW-1:0] reg_dest;
    logic signed [31:0] reg_value;
    logic               mem_written;
    logic [8:0]         mem_address;
    logic               mem_fault;
  } srisc_out_t;

  // execute stage outcome
  typedef struct packed {
    logic [11:0]        pc_next;
    logic               reg_we;
    logic [RegIdxW-1:0] reg_dest;
    logic [31:0]        reg_value;
    logic               is_load;
    logic               is_store;
    logic               mem_ok;
    logic [8:0]         mem_address;
  } ex_res_t;

endpackage

### src/srisc_exec.sv
// execute stage: alu, branch and jump target, load/store address check
// depends on srisc_pkg
module srisc_exec #(
  parameter int MEMORY_WORDS = srisc_pkg::MemWordsDef,
  localparam int AW = $clog2(MEMORY_WORDS)
) (
  input  logic [15:0]         instr_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  logic [11:0]         pc_i,
  input  logic [9:0]          prog_words_i,
  output srisc_pkg::ex_res_t  res_o,
  output logic [AW-1:0]       addr_o
);

  logic [3:0]  opc;
  logic [2:0]  rt;
  logic [2:0]  rd;
  logic [2:0]  fn;
  logic [5:0]  imm;
  logic [31:0] alu_val;
  logic [31:0] sum_val;
  logic [33:0] addr_full;
  logic        addr_ok;
  logic [11:0] pc_inc;

  assign opc    = instr_i[15:12];
  assign rt     = instr_i[8:6];
  assign rd     = instr_i[5:3];
  assign fn     = instr_i[2:0];
  assign imm    = instr_i[5:0];
  assign pc_inc = pc_i + 12'd1;

  always_comb begin
    unique case (fn)
      srisc_pkg::FnAdd: alu_val = a_i + b_i;
      srisc_pkg::FnSub: alu_val = a_i - b_i;
      srisc_pkg::FnAnd: alu_val = a_i & b_i;
      srisc_pkg::FnOr:  alu_val = a_i | b_i;
      default:          alu_val = '0;
    endcase
  end

  // data address is program size plus the signed 32-bit sum
  assign sum_val   = a_i + 32'(imm);
  assign addr_full = 34'(prog_words_i) + {{2{sum_val[31]}}, sum_val};
  assign addr_ok   = !addr_full[33] && (addr_full < 34'(MEMORY_WORDS));
  assign addr_o    = addr_full[AW-1:0];

  always_comb begin
    res_o         = '0;
    res_o.pc_next = pc_inc;
    unique case (opc) inside
      srisc_pkg::OpcRtype: begin
        res_o.reg_we    = 1'b1;
        res_o.reg_dest  = rd;
        res_o.reg_value = alu_val;
      end
      srisc_pkg::OpcJump: begin
        res_o.pc_next = instr_i[11:0];
      end
      srisc_pkg::OpcAddi: begin
        res_o.reg_we    = 1'b1;
        res_o.reg_dest  = rt;
        res_o.reg_value = sum_val;
      end
      srisc_pkg::OpcLw, srisc_pkg::OpcSw: begin
        res_o.is_load     = (opc == srisc_pkg::OpcLw);
        res_o.is_store    = (opc == srisc_pkg::OpcSw);
        res_o.reg_dest    = (opc == srisc_pkg::OpcLw) ? rt : '0;
        res_o.mem_ok      = addr_ok;
        res_o.mem_address = addr_ok ? addr_full[8:0] : '0;
      end
      srisc_pkg::OpcBeq: begin
        if (a_i == b_i) begin
          res_o.pc_next = pc_inc + 12'(imm);
        end
      end
      default: ;
    endcase
  end

endmodule

### src/sixteen_bit_risc_core_step.sv
// top level of the sixteen-bit risc core step block: sequencer, unified memory,
// register file and output register; depends on srisc_pkg and srisc_exec
//
//   port group     dir   handshake              carries
//   in_*           in    in_valid_i/in_stall_o  srisc_in_t request
//   out_*          out   out_valid_o/out_stall_i srisc_out_t result
//   cfg_*          in    cfg_we_i               program size, 10 bits
//
// a request runs from the accepting cycle to the edge that registers the result, and the next
// request is accepted at that same edge; memory write, register read, unused op and halted step
// end in fetch, an instruction runs fetch read, register read, execute, a load then a load state
// after reset a clearing pass zeroes all MEMORY_WORDS words, one per cycle, with in_stall_o
// high; config writes are taken throughout
// a result waits in the output register under out_stall_i; an idle core still takes a request
module sixteen_bit_risc_core_step #(
  parameter int MEMORY_WORDS = srisc_pkg::MemWordsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  srisc_pkg::srisc_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output srisc_pkg::srisc_out_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [9:0]            cfg_wdata_i
);

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int RW = srisc_pkg::RegIdxW;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;
  localparam logic [1:0] StLoad  = 2'd3;

  logic [1:0]            st_q, st_d;
  logic [11:0]           pc_q, pc_d;
  logic [9:0]            pw_q;
  logic                  clr_q;
  logic [AW-1:0]         clr_cnt_q;
  srisc_pkg::srisc_in_t  item_q;
  logic [15:0]           instr_q;
  logic [RW-1:0]         ld_dest_q;
  logic                  ld_ok_q;
  logic [8:0]            ld_addr_q;
  srisc_pkg::srisc_out_t out_q;
  logic                  out_vld_q;

  // unified memory with read bypass
  logic [15:0]   mem_q [MEMORY_WORDS];
  logic [15:0]   mem_rd_q, mem_bd_q;
  logic          mem_byp_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd, mem_rdata;

  // register file, two read ports, one write port
  logic [31:0]          rf_q [srisc_pkg::RegCount];
  logic [srisc_pkg::RegCount-1:0] rf_vld_q;
  logic [31:0]          rf_a_rd_q, rf_a_bd_q, rf_b_rd_q, rf_b_bd_q;
  logic                 rf_a_byp_q, rf_a_vld_q, rf_b_byp_q, rf_b_vld_q;
  logic                 rf_we, rf_re_a, rf_re_b;
  logic [RW-1:0]        rf_wa, rf_ra, rf_rb;
  logic [31:0]          rf_wd, rf_a_val, rf_b_val;

  srisc_pkg::ex_res_t    ex;
  logic [AW-1:0]         ex_addr;
  srisc_pkg::srisc_out_t res;
  logic                  res_fire, out_free, in_acc, go_exec, halt_now, pc_in_mem;
  logic [15:0]           fetch_word;
  logic [31:0]           ld_val;

  srisc_exec #(
    .MEMORY_WORDS(MEMORY_WORDS)
  ) u_exec (
    .instr_i      (instr_q),
    .a_i          (rf_a_val),
    .b_i          (rf_b_val),
    .pc_i         (pc_q),
    .prog_words_i (pw_q),
    .res_o        (ex),
    .addr_o       (ex_addr)
  );

  assign mem_rdata  = mem_byp_q ? mem_bd_q : mem_rd_q;
  assign rf_a_val   = rf_a_byp_q ? rf_a_bd_q : (rf_a_vld_q ? rf_a_rd_q : '0);
  assign rf_b_val   = rf_b_byp_q ? rf_b_bd_q : (rf_b_vld_q ? rf_b_rd_q : '0);
  assign pc_in_mem  = 13'(pc_q) < 13'(MEMORY_WORDS);
  assign fetch_word = pc_in_mem ? mem_rdata : '0;
  assign halt_now   = pc_q >= 12'(pw_q);
  assign ld_val     = ld_ok_q ? 32'(mem_rdata) : '0;
  assign out_free   = !out_vld_q || !out_stall_i;

  // result assembly and finish condition
  always_comb begin
    res                 = '0;
    res.program_counter = pc_q;
    res_fire            = 1'b0;
    go_exec             = 1'b0;
    unique case (st_q)
      StFetch: begin
        case (item_q.op)
          srisc_pkg::OpStep: begin
            if (halt_now) begin
              res.halted = 1'b1;
              res_fire   = out_free;
            end else begin
              go_exec = 1'b1;
            end
          end
          srisc_pkg::OpRead: begin
            res.reg_dest  = item_q.register_select;
            res.reg_value = rf_a_val;
            res_fire      = out_free;
          end
          default: res_fire = out_free;
        endcase
      end
      StExec: begin
        if (!ex.is_load) begin
          res.program_counter = ex.pc_next;
          res.reg_written     = ex.reg_we;
          res.reg_dest        = ex.reg_dest;
          res.reg_value       = ex.reg_value;
          res.mem_written     = ex.is_store && ex.mem_ok;
          res.mem_address     = ex.mem_address;
          res.mem_fault       = ex.is_store && !ex.mem_ok;
          res_fire            = out_free;
        end
      end
      StLoad: begin
        res.reg_written = 1'b1;
        res.reg_dest    = ld_dest_q;
        res.reg_value   = ld_val;
        res.mem_address = ld_addr_q;
        res.mem_fault   = !ld_ok_q;
        res_fire        = out_free;
      end
      default: ;
    endcase
  end

  // next request enters in the cycle the current one hands off its result
  assign in_stall_o = clr_q || !((st_q == StIdle) || res_fire);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    st_d = st_q;
    if (in_acc) begin
      st_d = StFetch;
    end else if (res_fire) begin
      st_d = StIdle;
    end else if (go_exec) begin
      st_d = StExec;
    end else if (st_q == StExec && ex.is_load) begin
      st_d = StLoad;
    end
  end

  // pc moves when the execute stage leaves; the fetch of a request taken at that
  // edge uses the new value
  assign pc_d = (st_q == StExec && (ex.is_load || res_fire)) ? ex.pc_next : pc_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_q;
    mem_wd = '0;
    if (clr_q) begin
      mem_we = 1'b1;
    end else if (st_q == StFetch && item_q.op == srisc_pkg::OpWrite && res_fire) begin
      mem_we = 13'(item_q.word_address) < 13'(MEMORY_WORDS);
      mem_wa = AW'(item_q.word_address);
      mem_wd = item_q.word_data;
    end else if (st_q == StExec && res_fire && ex.is_store && ex.mem_ok) begin
      mem_we = 1'b1;
      mem_wa = ex_addr;
      mem_wd = rf_b_val[15:0];
    end
  end

  assign mem_re = in_acc || (st_q == StExec && ex.is_load && ex.mem_ok);
  assign mem_ra = in_acc ? pc_d[AW-1:0] : ex_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q  <= mem_q[mem_ra];
      mem_byp_q <= mem_we && (mem_wa == mem_ra);
      mem_bd_q  <= mem_wd;
    end
  end

  always_comb begin
    rf_we = 1'b0;
    rf_wa = ex.reg_dest;
    rf_wd = ex.reg_value;
    if (st_q == StExec && res_fire && ex.reg_we) begin
      rf_we = 1'b1;
    end else if (st_q == StLoad && res_fire) begin
      rf_we = 1'b1;
      rf_wa = ld_dest_q;
      rf_wd = ld_val;
    end
  end

  assign rf_re_a = in_acc || go_exec;
  assign rf_ra   = in_acc ? in_data_i.register_select : fetch_word[11:9];
  assign rf_re_b = go_exec;
  assign rf_rb   = fetch_word[8:6];

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
    if (rf_re_a) begin
      rf_a_rd_q  <= rf_q[rf_ra];
      rf_a_byp_q <= rf_we && (rf_wa == rf_ra);
      rf_a_bd_q  <= rf_wd;
    end
    if (rf_re_b) begin
      rf_b_rd_q  <= rf_q[rf_rb];
      rf_b_byp_q <= rf_we && (rf_wa == rf_rb);
      rf_b_bd_q  <= rf_wd;
    end
  end

  // entries read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q   <= '0;
      rf_a_vld_q <= 1'b0;
      rf_b_vld_q <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
      if (rf_re_a) begin
        rf_a_vld_q <= rf_vld_q[rf_ra];
      end
      if (rf_re_b) begin
        rf_b_vld_q <= rf_vld_q[rf_rb];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      pc_q      <= '0;
      pw_q      <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pc_q <= pc_d;
      if (cfg_we_i) begin
        pw_q <= cfg_wdata_i;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MEMORY_WORDS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (res_fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (go_exec) begin
      instr_q <= fetch_word;
    end
    if (st_q == StExec && ex.is_load) begin
      ld_dest_q <= ex.reg_dest;
      ld_ok_q   <= ex.mem_ok;
      ld_addr_q <= ex.mem_address;
    end
    if (res_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_acc)
    else $error("request taken during memory clearing pass");

  a_acc_to_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> st_q == StFetch)
    else $error("accepted request did not enter fetch");

  a_pc_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StExec |=> pc_q == $past(pc_q))
    else $error("pc changed outside execute");

  a_halt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res.halted |-> !rf_we && !mem_we)
    else $error("halted step changed state");

  a_one_mem_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && st_q == StExec && ex.is_store && ex.mem_ok |-> mem_we && !clr_q)
    else $error("in-range store did not reach memory");

endmodule
